// File: hdl/rmsp_pkg.sv
// Package for the route message stream parser: phase encoding, field tags,
// status codes, register indexes and the shared result and config types.
// No dependencies.
package rmsp_pkg;

  localparam int DEFAULT_MAX_NEXTHOPS = 16;

  localparam logic [15:0] HDR_BYTES   = 16'd10;
  localparam logic [7:0]  MARK_BYTE   = 8'd254;
  localparam int          WEIGHT_BIT  = 2;       // flag value 0x04
  localparam logic [31:0] V4_MAX_PLEN = 32'd32;
  localparam logic [31:0] V6_MAX_PLEN = 32'd128;

  typedef enum logic [4:0] {
    PH_HDR, PH_TYPE, PH_INST, PH_FLAGS, PH_MSG, PH_SAFI, PH_FAM, PH_PLEN,
    PH_PFX, PH_NHG, PH_NHCNT, PH_NHVRF, PH_NHTYPE, PH_NHFLAGS, PH_GW,
    PH_IFX, PH_WEIGHT, PH_DONE
  } phase_t;

  localparam logic [4:0] TAG_VRF        = 5'd0;
  localparam logic [4:0] TAG_COMMAND    = 5'd1;
  localparam logic [4:0] TAG_TYPE       = 5'd2;
  localparam logic [4:0] TAG_INSTANCE   = 5'd3;
  localparam logic [4:0] TAG_FLAGS      = 5'd4;
  localparam logic [4:0] TAG_MESSAGE    = 5'd5;
  localparam logic [4:0] TAG_SAFI       = 5'd6;
  localparam logic [4:0] TAG_FAMILY     = 5'd7;
  localparam logic [4:0] TAG_PREFIXLEN  = 5'd8;
  localparam logic [4:0] TAG_PREFIXBYTE = 5'd9;
  localparam logic [4:0] TAG_NHG        = 5'd10;
  localparam logic [4:0] TAG_NHCOUNT    = 5'd11;
  localparam logic [4:0] TAG_NHTYPE     = 5'd12;
  localparam logic [4:0] TAG_NHFLAGS    = 5'd13;
  localparam logic [4:0] TAG_GWBYTE     = 5'd14;
  localparam logic [4:0] TAG_IFINDEX    = 5'd15;
  localparam logic [4:0] TAG_STATUS     = 5'd16;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_SHORT       = 4'd1;
  localparam logic [3:0] ST_BAD_LENGTH  = 4'd2;
  localparam logic [3:0] ST_BAD_HEADER  = 4'd3;
  localparam logic [3:0] ST_TR_ROUTE    = 4'd4;
  localparam logic [3:0] ST_BAD_PREFIX  = 4'd5;
  localparam logic [3:0] ST_TR_NHG      = 4'd6;
  localparam logic [3:0] ST_BAD_COUNT   = 4'd7;
  localparam logic [3:0] ST_TR_NHHDR    = 4'd8;
  localparam logic [3:0] ST_TR_ADDR     = 4'd9;
  localparam logic [3:0] ST_TR_WEIGHT   = 4'd10;

  localparam logic [7:0] NH_IFINDEX    = 8'd1;
  localparam logic [7:0] NH_GATEWAY    = 8'd2;
  localparam logic [7:0] NH_GATEWAY_IF = 8'd3;

  localparam logic [2:0] REG_EXPECTED_VERSION = 3'd0;
  localparam logic [2:0] REG_NHG_MASK         = 3'd1;
  localparam logic [2:0] REG_NHLIST_MASK      = 3'd2;
  localparam logic [2:0] REG_NH_LIMIT         = 3'd3;
  localparam logic [2:0] REG_IPV4_CODE        = 3'd4;
  localparam logic [2:0] REG_IPV6_CODE        = 3'd5;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    logic [4:0]  tag;
    logic [31:0] value;
    logic [3:0]  index;
    logic [3:0]  nexthop;
    logic [3:0]  status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [31:0] nhg_mask;
    logic [31:0] nhlist_mask;
    logic [4:0]  nh_limit;
    logic [7:0]  ipv4_code;
    logic [7:0]  ipv6_code;
  } cfg_t;

  // Status given when the payload ends inside a field of this phase.
  function automatic logic [3:0] trunc_code(input phase_t ph);
    logic [3:0] code;
    case (ph)
      PH_TYPE, PH_INST, PH_FLAGS, PH_MSG, PH_SAFI, PH_FAM, PH_PLEN: code = ST_TR_ROUTE;
      PH_PFX:                          code = ST_BAD_PREFIX;
      PH_NHG:                          code = ST_TR_NHG;
      PH_NHCNT:                        code = ST_BAD_COUNT;
      PH_NHVRF, PH_NHTYPE, PH_NHFLAGS: code = ST_TR_NHHDR;
      PH_GW, PH_IFX:                   code = ST_TR_ADDR;
      PH_WEIGHT:                       code = ST_TR_WEIGHT;
      default:                         code = ST_OK;
    endcase
    return code;
  endfunction

endpackage

// File: hdl/rmsp_parser.sv
// Byte-level field parser: holds the parse state and turns one byte into
// up to two results (a decoded field and the end-of-buffer status).
// Depends on rmsp_pkg.
module rmsp_parser #(
  parameter int MAX_NEXTHOPS = rmsp_pkg::DEFAULT_MAX_NEXTHOPS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             end_of_buffer,
  input  rmsp_pkg::cfg_t   cfg,
  output rmsp_pkg::result_t result0,
  output rmsp_pkg::result_t result1,
  output logic [1:0]       result_count,
  output logic             at_start
);
  import rmsp_pkg::*;

  localparam int CW = $clog2(MAX_NEXTHOPS + 1);
  localparam logic [15:0] MaxNh = 16'(MAX_NEXTHOPS);

  phase_t        phase, phase_next;
  logic [15:0]   byte_position, byte_position_next;
  logic [15:0]   message_length, message_length_next;
  logic [31:0]   field_accumulator, field_accumulator_next;
  logic [4:0]    field_bytes_left, field_bytes_left_next;
  logic [7:0]    route_family, route_family_next;
  logic [7:0]    prefix_length, prefix_length_next;
  logic [31:0]   message_bits, message_bits_next;
  logic [15:0]   nexthops_total, nexthops_total_next;
  logic [CW-1:0] nexthop_counter, nexthop_counter_next;
  logic [7:0]    nexthop_type, nexthop_type_next;
  logic [7:0]    nexthop_flags, nexthop_flags_next;
  logic [3:0]    error_code, error_code_next;

  logic [31:0] acc_shift;
  logic [4:0]  bl_dec;
  logic [4:0]  gw_size;
  logic [5:0]  pfx_total;
  logic [15:0] lim;
  logic [CW-1:0] cnt_inc;
  logic [31:0] nh_wide;
  logic        is4, is6;
  logic        field_valid;
  result_t     field_res, status_res;
  logic [3:0]  status;

  always_comb begin
    phase_next             = phase;
    byte_position_next     = byte_position;
    message_length_next    = message_length;
    field_accumulator_next = field_accumulator;
    field_bytes_left_next  = field_bytes_left;
    route_family_next      = route_family;
    prefix_length_next     = prefix_length;
    message_bits_next      = message_bits;
    nexthops_total_next    = nexthops_total;
    nexthop_counter_next   = nexthop_counter;
    nexthop_type_next      = nexthop_type;
    nexthop_flags_next     = nexthop_flags;
    error_code_next        = error_code;
    field_valid            = 1'b0;
    field_res              = '0;
    status_res             = '0;
    status                 = ST_OK;

    acc_shift = {field_accumulator[23:0], data_byte};
    bl_dec    = (field_bytes_left != 5'd0) ? field_bytes_left - 5'd1 : 5'd0;
    gw_size   = (route_family == cfg.ipv4_code) ? 5'd4 : 5'd16;
    pfx_total = 6'((9'(prefix_length) + 9'd7) >> 3);
    lim       = (16'(cfg.nh_limit) < MaxNh) ? 16'(cfg.nh_limit) : MaxNh;
    cnt_inc   = nexthop_counter + 1'b1;
    nh_wide   = 32'(nexthop_counter);
    is4       = (route_family == cfg.ipv4_code);
    is6       = (route_family == cfg.ipv6_code);

    if (error_code == ST_OK && phase != PH_DONE) begin
      if (phase == PH_HDR) begin
        case (byte_position)
          16'd0: field_accumulator_next = 32'(data_byte);
          16'd1: begin
            message_length_next = {field_accumulator[7:0], data_byte};
            if ({field_accumulator[7:0], data_byte} < HDR_BYTES) begin
              error_code_next = ST_BAD_LENGTH;
            end
          end
          16'd2: if (data_byte != MARK_BYTE) error_code_next = ST_BAD_HEADER;
          16'd3: if (data_byte != cfg.expected_version) error_code_next = ST_BAD_HEADER;
          16'd4: field_accumulator_next = 32'(data_byte);
          16'd5, 16'd6: field_accumulator_next = acc_shift;
          16'd7: begin
            field_valid     = 1'b1;
            field_res.tag   = TAG_VRF;
            field_res.value = acc_shift;
          end
          16'd8: field_accumulator_next = 32'(data_byte);
          16'd9: begin
            field_valid            = 1'b1;
            field_res.tag          = TAG_COMMAND;
            field_res.value        = 32'({field_accumulator[7:0], data_byte});
            phase_next             = PH_TYPE;
            field_bytes_left_next  = 5'd1;
            field_accumulator_next = '0;
          end
          default: phase_next = PH_DONE;
        endcase
      end else begin
        if (phase == PH_PFX) begin
          field_valid     = 1'b1;
          field_res.tag   = TAG_PREFIXBYTE;
          field_res.value = 32'(data_byte);
          field_res.index = 4'(pfx_total - {1'b0, field_bytes_left});
        end else if (phase == PH_GW) begin
          field_valid       = 1'b1;
          field_res.tag     = TAG_GWBYTE;
          field_res.value   = 32'(data_byte);
          field_res.index   = 4'(gw_size - field_bytes_left);
          field_res.nexthop = nh_wide[3:0];
        end
        field_accumulator_next = acc_shift;
        field_bytes_left_next  = bl_dec;
        if (bl_dec == 5'd0) begin
          // The field is complete: act on its value and pick the next one.
          case (phase)
            PH_TYPE, PH_INST, PH_FLAGS, PH_MSG, PH_SAFI, PH_FAM: begin
              field_valid            = 1'b1;
              field_res.value        = acc_shift;
              field_accumulator_next = '0;
              case (phase)
                PH_TYPE: begin
                  field_res.tag = TAG_TYPE;
                  phase_next = PH_INST; field_bytes_left_next = 5'd2;
                end
                PH_INST: begin
                  field_res.tag = TAG_INSTANCE;
                  phase_next = PH_FLAGS; field_bytes_left_next = 5'd4;
                end
                PH_FLAGS: begin
                  field_res.tag = TAG_FLAGS;
                  phase_next = PH_MSG; field_bytes_left_next = 5'd4;
                end
                PH_MSG: begin
                  field_res.tag = TAG_MESSAGE;
                  message_bits_next = acc_shift;
                  phase_next = PH_SAFI; field_bytes_left_next = 5'd1;
                end
                PH_SAFI: begin
                  field_res.tag = TAG_SAFI;
                  phase_next = PH_FAM; field_bytes_left_next = 5'd1;
                end
                default: begin
                  field_res.tag = TAG_FAMILY;
                  route_family_next = acc_shift[7:0];
                  phase_next = PH_PLEN; field_bytes_left_next = 5'd1;
                end
              endcase
            end
            PH_PLEN: begin
              prefix_length_next = acc_shift[7:0];
              field_valid        = 1'b1;
              field_res.tag      = TAG_PREFIXLEN;
              field_res.value    = acc_shift;
              if ((!is4 && !is6) || (is4 && acc_shift > V4_MAX_PLEN) ||
                  (is6 && acc_shift > V6_MAX_PLEN)) begin
                error_code_next = ST_BAD_PREFIX;
              end else if (acc_shift != 32'd0) begin
                phase_next             = PH_PFX;
                field_bytes_left_next  = 5'((acc_shift[8:0] + 9'd7) >> 3);
                field_accumulator_next = '0;
              end else if ((message_bits & cfg.nhg_mask) != 32'd0) begin
                phase_next = PH_NHG; field_bytes_left_next = 5'd4;
                field_accumulator_next = '0;
              end else if ((message_bits & cfg.nhlist_mask) != 32'd0) begin
                phase_next = PH_NHCNT; field_bytes_left_next = 5'd2;
                field_accumulator_next = '0;
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_PFX, PH_NHG: begin
              if (phase == PH_NHG) begin
                field_valid     = 1'b1;
                field_res.tag   = TAG_NHG;
                field_res.value = acc_shift;
              end
              if (phase == PH_PFX && (message_bits & cfg.nhg_mask) != 32'd0) begin
                phase_next = PH_NHG; field_bytes_left_next = 5'd4;
                field_accumulator_next = '0;
              end else if ((message_bits & cfg.nhlist_mask) != 32'd0) begin
                phase_next = PH_NHCNT; field_bytes_left_next = 5'd2;
                field_accumulator_next = '0;
              end else begin
                phase_next = PH_DONE;
              end
            end
            PH_NHCNT: begin
              nexthops_total_next = acc_shift[15:0];
              field_valid         = 1'b1;
              field_res.tag       = TAG_NHCOUNT;
              field_res.value     = 32'(acc_shift[15:0]);
              if (acc_shift[15:0] > lim) begin
                error_code_next = ST_BAD_COUNT;
              end else begin
                nexthop_counter_next = '0;
                if (acc_shift[15:0] != 16'd0) begin
                  phase_next = PH_NHVRF; field_bytes_left_next = 5'd4;
                  field_accumulator_next = '0;
                end else begin
                  phase_next = PH_DONE;
                end
              end
            end
            PH_NHVRF: begin
              phase_next = PH_NHTYPE; field_bytes_left_next = 5'd1;
              field_accumulator_next = '0;
            end
            PH_NHTYPE: begin
              nexthop_type_next = acc_shift[7:0];
              field_valid       = 1'b1;
              field_res.tag     = TAG_NHTYPE;
              field_res.value   = acc_shift;
              field_res.nexthop = nh_wide[3:0];
              phase_next = PH_NHFLAGS; field_bytes_left_next = 5'd1;
              field_accumulator_next = '0;
            end
            PH_NHFLAGS, PH_GW, PH_IFX, PH_WEIGHT: begin
              if (phase == PH_NHFLAGS) begin
                nexthop_flags_next = acc_shift[7:0];
                field_valid        = 1'b1;
                field_res.tag      = TAG_NHFLAGS;
                field_res.value    = acc_shift;
                field_res.nexthop  = nh_wide[3:0];
              end else if (phase == PH_IFX) begin
                field_valid        = 1'b1;
                field_res.tag      = TAG_IFINDEX;
                field_res.value    = acc_shift;
                field_res.nexthop  = nh_wide[3:0];
              end
              if (phase == PH_NHFLAGS && nexthop_type == NH_IFINDEX) begin
                phase_next = PH_IFX; field_bytes_left_next = 5'd4;
                field_accumulator_next = '0;
              end else if (phase == PH_NHFLAGS && (nexthop_type == NH_GATEWAY ||
                           nexthop_type == NH_GATEWAY_IF)) begin
                phase_next = PH_GW; field_bytes_left_next = gw_size;
                field_accumulator_next = '0;
              end else if (phase == PH_GW && nexthop_type == NH_GATEWAY_IF) begin
                phase_next = PH_IFX; field_bytes_left_next = 5'd4;
                field_accumulator_next = '0;
              end else if (phase != PH_WEIGHT &&
                           ((phase == PH_NHFLAGS) ? acc_shift[WEIGHT_BIT]
                                                  : nexthop_flags[WEIGHT_BIT])) begin
                phase_next = PH_WEIGHT; field_bytes_left_next = 5'd8;
                field_accumulator_next = '0;
              end else begin
                // This nexthop is finished; start the next one or stop.
                nexthop_counter_next = cnt_inc;
                if (16'(cnt_inc) < nexthops_total) begin
                  phase_next = PH_NHVRF; field_bytes_left_next = 5'd4;
                  field_accumulator_next = '0;
                end else begin
                  phase_next = PH_DONE;
                end
              end
            end
            default: phase_next = PH_DONE;
          endcase
        end
      end
      if (error_code_next == ST_OK && phase_next != PH_HDR && phase_next != PH_DONE &&
          (17'(byte_position) + 17'd1) == 17'(message_length_next)) begin
        error_code_next = trunc_code(phase_next);
      end
    end

    byte_position_next = (byte_position != 16'hFFFF) ? byte_position + 16'd1
                                                      : byte_position;

    if (end_of_buffer) begin
      if (byte_position_next < HDR_BYTES) begin
        status = ST_SHORT;
      end else if (message_length_next < HDR_BYTES ||
                   byte_position_next < message_length_next) begin
        status = ST_BAD_LENGTH;
      end else begin
        status = error_code_next;
      end
      status_res.tag    = TAG_STATUS;
      status_res.value  = 32'(status);
      status_res.status = status;
      status_res.last   = 1'b1;
      phase_next             = PH_HDR;
      byte_position_next     = '0;
      message_length_next    = '0;
      field_accumulator_next = '0;
      field_bytes_left_next  = '0;
      route_family_next      = '0;
      prefix_length_next     = '0;
      message_bits_next      = '0;
      nexthops_total_next    = '0;
      nexthop_counter_next   = '0;
      nexthop_type_next      = '0;
      nexthop_flags_next     = '0;
      error_code_next        = '0;
    end
  end

  always_comb begin
    result0      = field_valid ? field_res : status_res;
    result1      = status_res;
    result_count = 2'(field_valid) + 2'(end_of_buffer);
  end

  assign at_start = (byte_position == 16'd0) && (phase == PH_HDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR;
      byte_position     <= '0;
      message_length    <= '0;
      field_accumulator <= '0;
      field_bytes_left  <= '0;
      route_family      <= '0;
      prefix_length     <= '0;
      message_bits      <= '0;
      nexthops_total    <= '0;
      nexthop_counter   <= '0;
      nexthop_type      <= '0;
      nexthop_flags     <= '0;
      error_code        <= '0;
    end else if (accept) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      message_length    <= message_length_next;
      field_accumulator <= field_accumulator_next;
      field_bytes_left  <= field_bytes_left_next;
      route_family      <= route_family_next;
      prefix_length     <= prefix_length_next;
      message_bits      <= message_bits_next;
      nexthops_total    <= nexthops_total_next;
      nexthop_counter   <= nexthop_counter_next;
      nexthop_type      <= nexthop_type_next;
      nexthop_flags     <= nexthop_flags_next;
      error_code        <= error_code_next;
    end
  end

endmodule

// File: hdl/rmsp_result_fifo.sv
// Small result queue: takes up to two results per cycle, gives one while out_ready is high.
// Depends on rmsp_pkg.
module rmsp_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  rmsp_pkg::result_t push0,
  input  rmsp_pkg::result_t push1,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output rmsp_pkg::result_t head,
  output logic [2:0]        fill
);
  import rmsp_pkg::*;

  result_t    mem [FIFO_DEPTH];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 3'd0);
  assign head      = mem[rd_ptr];
  assign has_room  = (count <= 3'(FIFO_DEPTH - 2));
  assign fill      = count;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) mem[wr_ptr] <= push0;
    if (push_count == 2'd2) mem[wr_ptr + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(push_count) - 3'(pop);
    end
  end

endmodule

// File: hdl/route_message_stream_parser.sv
// Top level of the route message stream parser: configuration registers,
// byte parser and result queue. Depends on rmsp_pkg, rmsp_parser and
// rmsp_result_fifo.
//
// The block takes a routing-message buffer one byte per transfer and gives
// back tagged field results. Each byte is decoded in the cycle in which it
// is accepted, so a byte can be accepted in every clock cycle while the
// queue has room. A byte gives zero, one or two results (a decoded field
// and, on the byte flagged end_of_buffer, the final status with last set).
// Results wait in a four-entry queue; input is taken while the queue has
// room for two more results, which keeps one result per cycle flowing when
// the consumer is always ready. The results of a byte are registered in
// the queue and reach the output in order. Fields of a buffer are valid
// only when its status result reads zero. Configuration writes take effect
// at once and should be made only while no buffer is in flight.
module route_message_stream_parser #(
  parameter int MAX_NEXTHOPS = rmsp_pkg::DEFAULT_MAX_NEXTHOPS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [2:0]  register_index,
  input  logic [31:0] write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  field_tag,
  output logic [31:0] field_value,
  output logic [3:0]  byte_index,
  output logic [3:0]  nexthop_number,
  output logic [3:0]  status_code,
  output logic        last
);
  import rmsp_pkg::*;

  cfg_t       cfg;
  logic       accept;
  result_t    res0, res1, head;
  logic [1:0] res_count;
  logic       at_start;
  logic [2:0] fill;

  // Configuration registers; a write to an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= 8'd6;
      cfg.nhg_mask         <= 32'd32;
      cfg.nhlist_mask      <= 32'd1;
      cfg.nh_limit         <= 5'd16;
      cfg.ipv4_code        <= 8'd2;
      cfg.ipv6_code        <= 8'd10;
    end else if (write_enable) begin
      case (register_index)
        REG_EXPECTED_VERSION: cfg.expected_version <= write_data[7:0];
        REG_NHG_MASK:         cfg.nhg_mask         <= write_data;
        REG_NHLIST_MASK:      cfg.nhlist_mask      <= write_data;
        REG_NH_LIMIT:         cfg.nh_limit         <= write_data[4:0];
        REG_IPV4_CODE:        cfg.ipv4_code        <= write_data[7:0];
        REG_IPV6_CODE:        cfg.ipv6_code        <= write_data[7:0];
        default: ;
      endcase
    end
  end

  // A byte is decoded in the cycle of its transfer.
  assign accept = in_valid && in_ready;

  rmsp_parser #(.MAX_NEXTHOPS(MAX_NEXTHOPS)) u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .cfg          (cfg),
    .result0      (res0),
    .result1      (res1),
    .result_count (res_count),
    .at_start     (at_start)
  );

  rmsp_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_count(accept ? res_count : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .fill      (fill)
  );

  assign field_tag      = head.tag;
  assign field_value    = head.value;
  assign byte_index     = head.index;
  assign nexthop_number = head.nexthop;
  assign status_code    = head.status;
  assign last           = head.last;

  // The queue never holds more than its depth.
  assert property (@(posedge clk) disable iff (rst) fill <= 3'(FIFO_DEPTH))
    else $error("result queue overflow");

  // After the last byte of a buffer the parser is back at its start.
  assert property (@(posedge clk) disable iff (rst)
    accept && end_of_buffer |=> at_start)
    else $error("parser not cleared after end of buffer");

  // Only the status result is marked last.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> field_tag == TAG_STATUS)
    else $error("last set on a field result");

  // A byte that gives a status also empties the queue only in order: with
  // the queue empty, a last-byte transfer shows a result next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept && end_of_buffer && fill == 3'd0 |=> out_valid)
    else $error("status result lost");

endmodule
